@@ src/rsrc_pkg.sv @@
package rsrc_pkg;

    localparam int OPERAND_WIDTH = 32;

    localparam logic [1:0] OP_NORM = 2'd0;
    localparam logic [1:0] OP_SUB  = 2'd1;
    localparam logic [1:0] OP_NEG  = 2'd2;
    localparam logic [1:0] OP_CMP  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZDEN  = 2'd1;
    localparam logic [1:0] ST_WIDE  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } req_t;

    typedef struct packed {
        logic [63:0] res_num;
        logic [63:0] res_den;
        logic [1:0]  cmp_sign;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [63:0] rem;
    } div_rsp_t;

endpackage

@@ src/rsrc_if.sv @@
interface rsrc_req_if;
    import rsrc_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/rsrc_rsp_if.sv @@
interface rsrc_rsp_if;
    import rsrc_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/rsrc_div.sv @@
// Restoring divider, one quotient bit per cycle.
module rsrc_div
    import rsrc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] d_reg, d_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        shifted   = {r_reg, q_reg[63]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            q_next    = req.dividend;
            r_next    = '0;
            d_next    = req.divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so 64 bits hold it
            if (shifted >= {1'b0, d_reg})
            begin
                r_next = 64'(shifted - {1'b0, d_reg});
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = shifted[63:0];
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg;
endmodule

@@ src/rational_subtract_reduce_compare.sv @@
// Rational subtract / reduce / compare. One beat in, one beat out; the block
// takes one item at a time. Negate and error results go from S_DISP straight to
// S_OUT; compare passes S_M0, S_M1, S_M2 and S_SUB on the way.
// Subtract and normalize run Euclid's loop on one shared restoring divider:
// each remainder step is one division, then two more divisions reduce
// numerator and denominator. A result held by the receiver stalls the block
// until it is taken. The single 32x32 multiplier forms the three cross
// products in S_M0, S_M1 and S_M2.
module rational_subtract_reduce_compare
    import rsrc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    rsrc_req_if.sink   in_ch,
    rsrc_rsp_if.source out_ch
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_SUB  = 4'd4;
    localparam logic [3:0] S_GCD  = 4'd5;
    localparam logic [3:0] S_GW   = 4'd6;
    localparam logic [3:0] S_DN   = 4'd7;
    localparam logic [3:0] S_DNW  = 4'd8;
    localparam logic [3:0] S_DDW  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;
    localparam logic [3:0] S_DISP = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  op_reg;
    logic        an_s, ad_s, bn_s, bd_s;
    logic [31:0] an_m, ad_m, bn_m, bd_m;
    logic [63:0] p0_reg, p1_reg, nmag_reg, dmag_reg, ga_reg, gb_reg, qn_reg;
    logic        nneg_reg, dneg_reg;
    rsp_t        rsp_reg;
    logic        ov_reg;

    logic [OPERAND_WIDTH-1:0] fa, fb, fc, fd;
    logic [31:0] ma, mb;
    logic [63:0] prod;
    div_req_t dreq;
    div_rsp_t drsp;

    function automatic logic [32:0] tk(input logic [OPERAND_WIDTH-1:0] v);
        logic [31:0] ext;
        ext = 32'($signed(v));
        tk  = ext[31] ? {1'b1, 32'(-ext)} : {1'b0, ext};
    endfunction

    assign fa = in_ch.data.a_num[OPERAND_WIDTH-1:0];
    assign fb = in_ch.data.a_den[OPERAND_WIDTH-1:0];
    assign fc = in_ch.data.b_num[OPERAND_WIDTH-1:0];
    assign fd = in_ch.data.b_den[OPERAND_WIDTH-1:0];

    rsrc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_comb
    begin
        unique case (state_reg)
            S_M0:    begin ma = an_m; mb = bd_m; end
            S_M1:    begin ma = ad_m; mb = bn_m; end
            default: begin ma = ad_m; mb = bd_m; end
        endcase
    end
    assign prod = {32'd0, ma} * {32'd0, mb};

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data  = rsp_reg;

    always_comb
    begin
        dreq = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_ch.valid) state_next = S_DISP;
            S_DISP:
            begin
                if (ad_m == 32'd0 || ((op_reg == OP_SUB || op_reg == OP_CMP) && bd_m == 32'd0))
                    state_next = S_OUT;
                else if (op_reg == OP_NEG)
                    state_next = S_OUT;
                else if (op_reg == OP_NORM)
                    state_next = S_GCD;
                else
                    state_next = S_M0;
            end
            S_M0:  state_next = S_M1;
            S_M1:  state_next = S_M2;
            S_M2:  state_next = S_SUB;
            S_SUB: state_next = (op_reg == OP_CMP) ? S_OUT : S_GCD;
            S_GCD:
            begin
                if (gb_reg == 64'd0)
                begin
                    dreq = '{start: 1'b1, dividend: nmag_reg, divisor: ga_reg};
                    state_next = S_DNW;
                end
                else
                begin
                    dreq = '{start: 1'b1, dividend: ga_reg, divisor: gb_reg};
                    state_next = S_GW;
                end
            end
            S_GW:  if (drsp.done) state_next = S_GCD;
            S_DNW: if (drsp.done) state_next = S_DN;
            S_DN:
            begin
                dreq = '{start: 1'b1, dividend: dmag_reg, divisor: ga_reg};
                state_next = S_DDW;
            end
            S_DDW: if (drsp.done) state_next = S_OUT;
            S_OUT: if (out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            if (in_ch.valid)
            begin
                op_reg <= in_ch.data.opcode;
                {an_s, an_m} <= tk(fa);
                {ad_s, ad_m} <= tk(fb);
                {bn_s, bn_m} <= tk(fc);
                {bd_s, bd_m} <= tk(fd);
            end
            S_DISP:
            begin
                rsp_reg <= '0;
                nmag_reg <= {32'd0, an_m};
                dmag_reg <= {32'd0, ad_m};
                nneg_reg <= an_s;
                dneg_reg <= ad_s;
                ga_reg <= {32'd0, an_m};
                gb_reg <= {32'd0, ad_m};
                if (ad_m == 32'd0 || ((op_reg == OP_SUB || op_reg == OP_CMP) && bd_m == 32'd0))
                    rsp_reg.status <= ST_ZDEN;
                else if (op_reg == OP_NEG)
                begin
                    rsp_reg.res_num <= (an_m != 0 && !an_s) ? -{32'd0, an_m} : {32'd0, an_m};
                    rsp_reg.res_den <= ad_s ? -{32'd0, ad_m} : {32'd0, ad_m};
                end
            end
            S_M0: p0_reg <= prod;
            S_M1: p1_reg <= prod;
            S_M2:
            begin
                dmag_reg <= prod;
                dneg_reg <= ad_s ^ bd_s;
            end
            S_SUB:
            begin
                // p0 sign an^bd, p1 sign ad^bn; n = p0 - p1
                if ((an_s ^ bd_s) != (ad_s ^ bn_s))
                begin
                    nmag_reg <= p0_reg + p1_reg;
                    nneg_reg <= an_s ^ bd_s;
                end
                else if (p0_reg >= p1_reg)
                begin
                    nmag_reg <= p0_reg - p1_reg;
                    nneg_reg <= an_s ^ bd_s;
                end
                else
                begin
                    nmag_reg <= p1_reg - p0_reg;
                    nneg_reg <= !(an_s ^ bd_s);
                end
                ga_reg <= ((an_s ^ bd_s) != (ad_s ^ bn_s)) ? p0_reg + p1_reg
                          : (p0_reg >= p1_reg) ? p0_reg - p1_reg : p1_reg - p0_reg;
                gb_reg <= dmag_reg;
                if (op_reg == OP_CMP)
                begin
                    // difference is zero when both products match in size and
                    // either their signs agree or both are zero
                    if (p0_reg == p1_reg
                        && ((an_s ^ bd_s) == (ad_s ^ bn_s) || p0_reg == 64'd0))
                        rsp_reg.cmp_sign <= 2'd0;
                    else if (((an_s ^ bd_s) != (ad_s ^ bn_s) || p0_reg >= p1_reg)
                             ? ((an_s ^ bd_s) != (ad_s ^ bd_s))
                             : ((an_s ^ bd_s) == (ad_s ^ bd_s)))
                        rsp_reg.cmp_sign <= 2'b11;
                    else
                        rsp_reg.cmp_sign <= 2'b01;
                end
            end
            S_GW:
            if (drsp.done)
            begin
                ga_reg <= gb_reg;
                gb_reg <= drsp.rem;
            end
            S_DNW:
            if (drsp.done)
            begin
                qn_reg <= drsp.quot;
                ov_reg <= (nmag_reg != 0 && (nneg_reg != dneg_reg))
                          ? (drsp.quot > 64'h8000_0000_0000_0000)
                          : drsp.quot[63];
            end
            S_DDW:
            if (drsp.done)
            begin
                if (ov_reg || drsp.quot[63])
                    rsp_reg.status <= ST_WIDE;
                else
                begin
                    rsp_reg.res_num <= (nmag_reg != 0 && (nneg_reg != dneg_reg)) ? -qn_reg : qn_reg;
                    rsp_reg.res_den <= drsp.quot;
                end
            end
            default: ;
        endcase
    end

    a_res_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("result and input ready at once");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
        else $error("result dropped while stalled");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.status != ST_OK) |->
        (out_ch.data.res_num == 64'd0 && out_ch.data.res_den == 64'd0))
        else $error("error result not zero");
endmodule

@@ dv/rational_subtract_reduce_compare_tb.sv @@
`timescale 1ns / 1ps

module rational_subtract_reduce_compare_tb;
    import rsrc_pkg::*;

    typedef struct {
        bit          neg;
        logic [63:0] mag;
    } sm_t;

    logic clk;
    logic rst_n;
    int   errors;
    bit   idle_en;
    int   hold_cycles;
    rsp_t rat_expected[$];

    rsrc_req_if in_ch();
    rsrc_rsp_if out_ch();

    rational_subtract_reduce_compare uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #400ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic sm_t to_sm(logic [31:0] raw);
        sm_t r;
        logic [63:0] v;
        v = {{32{raw[31]}}, raw};
        r.neg = raw[31];
        r.mag = raw[31] ? (64'd0 - v) : v;
        return r;
    endfunction

    function automatic sm_t sm_mul(sm_t x, sm_t y);
        sm_t r;
        r.mag = x.mag * y.mag;
        r.neg = (r.mag != 0) && (x.neg != y.neg);
        return r;
    endfunction

    function automatic logic [63:0] sm_enc(sm_t x);
        return x.neg ? (64'd0 - x.mag) : x.mag;
    endfunction

    function automatic bit sm_fits(sm_t x);
        return x.neg ? (x.mag <= 64'h8000_0000_0000_0000) : (x.mag[63] == 1'b0);
    endfunction

    function automatic rsp_t reduce_fraction(sm_t n, sm_t d);
        rsp_t r;
        sm_t rn, rd;
        logic [63:0] ga, gb, gc;
        ga = n.mag;
        gb = d.mag;
        while (gb != 0)
        begin
            gc = ga % gb;
            ga = gb;
            gb = gc;
        end
        rn.neg = (n.mag != 0) && (n.neg != d.neg);
        rn.mag = n.mag / ga;
        rd.neg = 1'b0;
        rd.mag = d.mag / ga;
        r = '0;
        if (!sm_fits(rn) || !sm_fits(rd))
            r.status = ST_WIDE;
        else
        begin
            r.res_num = sm_enc(rn);
            r.res_den = sm_enc(rd);
            r.status  = ST_OK;
        end
        return r;
    endfunction

    function automatic rsp_t rational_predict(req_t q);
        rsp_t r;
        sm_t an, ad, bn, bd, n, d, x, y;
        an = to_sm(q.a_num);
        ad = to_sm(q.a_den);
        bn = to_sm(q.b_num);
        bd = to_sm(q.b_den);
        r = '0;
        if (q.opcode == OP_NORM || q.opcode == OP_NEG)
        begin
            if (ad.mag == 0)
                r.status = ST_ZDEN;
            else if (q.opcode == OP_NORM)
                r = reduce_fraction(an, ad);
            else
            begin
                if (an.mag != 0)
                    an.neg = !an.neg;
                r.res_num = sm_enc(an);
                r.res_den = sm_enc(ad);
            end
            return r;
        end
        if (ad.mag == 0 || bd.mag == 0)
        begin
            r.status = ST_ZDEN;
            return r;
        end
        x = sm_mul(an, bd);
        y = sm_mul(ad, bn);
        y.neg = !y.neg;
        // sign-magnitude add of x and -y
        if (x.neg == y.neg)
        begin
            n.mag = x.mag + y.mag;
            n.neg = x.neg;
        end
        else if (x.mag >= y.mag)
        begin
            n.mag = x.mag - y.mag;
            n.neg = x.neg;
        end
        else
        begin
            n.mag = y.mag - x.mag;
            n.neg = y.neg;
        end
        if (n.mag == 0)
            n.neg = 1'b0;
        d = sm_mul(ad, bd);
        if (q.opcode == OP_SUB)
            r = reduce_fraction(n, d);
        else if (n.mag == 0)
            r.cmp_sign = 2'b00;
        else if (n.neg != d.neg)
            r.cmp_sign = 2'b11;
        else
            r.cmp_sign = 2'b01;
        return r;
    endfunction

    // sender: inputs change on the falling edge, valid left high between beats unless an idle gap is inserted
    task automatic send_item(req_t q);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = q;
        do
            @(posedge clk);
        while (!in_ch.ready);
        rat_expected.push_back(rational_predict(q));
        @(negedge clk);
    endtask

    task automatic send_op(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
        req_t q;
        q.opcode = op;
        q.a_num  = an;
        q.a_den  = ad;
        q.b_num  = bn;
        q.b_den  = bd;
        send_item(q);
    endtask

    // mode 0: small, 1: 16-bit, 2: full width, 3: corner values
    function automatic logic [31:0] rand_operand(int mode);
        case (mode)
            0: return 32'($signed($urandom_range(0, 40)) - 20);
            1: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            2: return $urandom;
            default:
                case ($urandom_range(0, 5))
                    0: return 32'd0;
                    1: return 32'd1;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h7FFF_FFFF;
                    4: return 32'h8000_0000;
                    default: return 32'h8000_0001;
                endcase
        endcase
    endfunction

    task automatic send_random(int count, int full_pct);
        int mode;
        repeat (count)
        begin
            mode = ($urandom_range(0, 99) < full_pct) ? 2 : $urandom_range(0, 3);
            if (mode == 2 && $urandom_range(0, 1) == 1)
                mode = 1;
            send_op(2'($urandom), rand_operand(mode), rand_operand(mode),
                    rand_operand(mode), rand_operand(mode));
        end
    endtask

    task automatic test_directed();
        send_op(OP_NORM, 32'd6, 32'd4, 32'd0, 32'd1);
        send_op(OP_NORM, 32'd6, -32'sd4, 32'd0, 32'd1);
        send_op(OP_NORM, 32'd0, -32'sd7, 32'd0, 32'd1);
        send_op(OP_NORM, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd1);
        send_op(OP_NORM, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1);
        send_op(OP_NORM, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd1);
        send_op(OP_NORM, 32'd5, 32'd0, 32'd3, 32'd1);
        send_op(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd3);
        send_op(OP_SUB, 32'd7, 32'd1, 32'd1, 32'd2);
        send_op(OP_SUB, 32'd1, 32'd2, 32'd7, 32'd1);
        send_op(OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_op(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001);
        send_op(OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_op(OP_SUB, 32'd3, 32'd0, 32'd1, 32'd1);
        send_op(OP_SUB, 32'd3, 32'd5, 32'd1, 32'd0);
        send_op(OP_NEG, 32'd3, -32'sd5, 32'd0, 32'd0);
        send_op(OP_NEG, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        send_op(OP_NEG, 32'd0, 32'd9, 32'd0, 32'd0);
        send_op(OP_NEG, 32'd1, 32'd0, 32'd0, 32'd0);
        send_op(OP_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
        send_op(OP_CMP, 32'd1, 32'd3, 32'd1, 32'd2);
        send_op(OP_CMP, -32'sd1, 32'd3, 32'd1, -32'sd2);
        send_op(OP_CMP, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'd1);
        send_op(OP_CMP, 32'd1, 32'd1, 32'd1, 32'd0);
    endtask

    // receiver holds off long enough for the input side to stall
    task automatic test_backpressure();
        hold_cycles = 400;
        send_random(6, 0);
    endtask

    task automatic test_random_mixed();
        send_random(1400, 12);
    endtask

    task automatic test_random_no_idle();
        idle_en = 1'b0;
        send_random(420, 8);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready = 1'b0;
        else if (hold_cycles > 0)
        begin
            out_ch.ready = 1'b0;
            hold_cycles  = hold_cycles - 1;
        end
        else if (idle_en && out_ch.ready && $urandom_range(0, 7) == 0)
        begin
            out_ch.ready = 1'b0;
            hold_cycles  = $urandom_range(0, 17);
        end
        else
            out_ch.ready = 1'b1;
    end

    always @(posedge clk)
    begin
        rsp_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (rat_expected.size() == 0)
            begin
                $error("result beat with nothing expected: %h", got);
                errors++;
            end
            else
            begin
                want = rat_expected.pop_front();
                if (got.res_num !== want.res_num)
                begin
                    $error("res_num expected %h actual %h", want.res_num, got.res_num);
                    errors++;
                end
                if (got.res_den !== want.res_den)
                begin
                    $error("res_den expected %h actual %h", want.res_den, got.res_den);
                    errors++;
                end
                if (got.cmp_sign !== want.cmp_sign)
                begin
                    $error("cmp_sign expected %b actual %b", want.cmp_sign, got.cmp_sign);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors       = 0;
        idle_en      = 1'b1;
        hold_cycles  = 0;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_random_mixed();
        test_random_no_idle();
        in_ch.valid = 1'b0;
        while (rat_expected.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
